// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, widths and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    // Default configuration of the block table
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 12;

    // Fixed field widths
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 24;
    localparam int STAT_W = 7;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 32'h0010_0000;
    localparam logic [SIZE_W-1:0] HEAP_BYTES_RST = 24'h01_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 2'd1;

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MEM   = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    // One table entry
    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MISS,
        OP_SCAN,
        OP_SHIFT_START,
        OP_SHIFT,
        OP_WR_ALLOC,
        OP_WR_REM,
        OP_WR_MARK,
        OP_COMP_START,
        OP_COMP,
        OP_COMP_END,
        OP_STAT_START,
        OP_STAT,
        OP_OUT
    } dp_op_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic init_pend;
        logic bad;
        logic hit;
        logic is_free;
        logic split;
        logic scan_done;
        logic shift_done;
        logic comp_done;
        logic stat_done;
    } dp_sts_t;

endpackage

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator with split and coalescing over a block table.
// ----------------------------------------------------------------------------
// Each word on the s_ channel is one allocate or free request and yields
// exactly one m_ word with the address, a status and usage statistics. One
// request is worked at a time. Every pass walks the block table through its
// memory (one write port, one registered read port) at one entry per cycle,
// so the time per request grows with the block count.
// A new request is taken while the previous result still waits on m_.
// After reset and after each register write the table is rebuilt as one free
// block, and no request is taken while that rebuild is pending.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [ADDR_W-1:0]    s_request_size,
    input  logic [ADDR_W-1:0]    s_free_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_result_address,
    output logic [1:0]           m_status,
    output logic [SIZE_W-1:0]    m_used_bytes,
    output logic [SIZE_W-1:0]    m_free_bytes,
    output logic [STAT_W-1:0]    m_total_blocks,
    output logic [STAT_W-1:0]    m_free_count
);

    dp_op_t  op;
    dp_sts_t sts;

    // Sequencer
    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .op      (op)
    );

    // Table and arithmetic
    ffha_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .op               (op),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_command        (s_command),
        .s_request_size   (s_request_size),
        .s_free_address   (s_free_address),
        .m_result_address (m_result_address),
        .m_status         (m_status),
        .m_used_bytes     (m_used_bytes),
        .m_free_bytes     (m_free_bytes),
        .m_total_blocks   (m_total_blocks),
        .m_free_count     (m_free_count)
    );

endmodule

// ===== rtl/ffha_datapath.sv =====
// ----------------------------------------------------------------------------
// ffha_datapath
// Block table memory, read stream, scan/shift/compaction/statistics passes,
// configuration registers and result registers.
// ----------------------------------------------------------------------------
module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_op_t               op,
    output dp_sts_t              sts,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 s_command,
    input  logic [ADDR_W-1:0]    s_request_size,
    input  logic [ADDR_W-1:0]    s_free_address,
    output logic [ADDR_W-1:0]    m_result_address,
    output logic [1:0]           m_status,
    output logic [SIZE_W-1:0]    m_used_bytes,
    output logic [SIZE_W-1:0]    m_free_bytes,
    output logic [STAT_W-1:0]    m_total_blocks,
    output logic [STAT_W-1:0]    m_free_count
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [ADDR_W-1:0] HDR_A     = ADDR_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] HDR_S     = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] SPLIT_MIN = SIZE_W'(HEADER_BYTES + 8);
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BLOCKS);

    // Table memory
    entry_t mem [MAX_BLOCKS];

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [SIZE_W-1:0] hbytes_reg, hbytes_next;
    logic              init_pend_reg, init_pend_next;
    logic              cmd_reg, cmd_next;
    logic [SIZE_W-1:0] sz_reg, sz_next;
    logic [ADDR_W-1:0] fa_reg, fa_next;
    logic              bad_reg, bad_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              p_vld_reg;
    logic [IDX_W-1:0]  p_idx_reg;
    entry_t            rdata_reg;
    logic [ADDR_W-1:0] a_reg, a_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [SIZE_W-1:0] hit_size_reg, hit_size_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  w_reg, w_next;
    entry_t            pend_reg, pend_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [SIZE_W-1:0] used_reg, used_next;
    logic [SIZE_W-1:0] frb_reg, frb_next;
    logic [CNT_W-1:0]  fb_reg, fb_next;

    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [1:0]        out_st_reg, out_st_next;
    logic [SIZE_W-1:0] out_used_reg, out_used_next;
    logic [SIZE_W-1:0] out_free_reg, out_free_next;
    logic [STAT_W-1:0] out_tot_reg, out_tot_next;
    logic [STAT_W-1:0] out_fb_reg, out_fb_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [ADDR_W-1:0] aligned;
    logic [SIZE_W-1:0] rem;
    logic              split;
    logic              stream_end;
    logic [CNT_W-1:0]  hit_idx_ext;
    entry_t            ef;

    assign aligned     = (s_request_size + ADDR_W'(7)) & ~ADDR_W'(7);
    assign rem         = hit_size_reg - sz_reg;
    assign split       = (rem > SPLIT_MIN) && (count_reg < MAX_CNT);
    assign hit_idx_ext = CNT_W'(hit_idx_reg);
    assign stream_end  = (rd_idx_reg >= count_reg) && !p_vld_reg;
    assign rd_addr     = rd_idx_reg[IDX_W-1:0];

    // Arriving entry, with the released block forced free
    always_comb begin
        ef = rdata_reg;
        if (p_idx_reg == hit_idx_reg) begin
            ef.free = 1'b1;
        end
    end

    // Status toward the controller
    always_comb begin
        sts.init_pend  = init_pend_reg;
        sts.bad        = bad_reg;
        sts.hit        = hit_reg;
        sts.is_free    = cmd_reg;
        sts.split      = split;
        sts.scan_done  = stream_end;
        sts.shift_done = !(rd_idx_reg > hit_idx_ext) && !p_vld_reg;
        sts.comp_done  = stream_end;
        sts.stat_done  = stream_end;
    end

    // Read enable per pass
    always_comb begin
        case (op)
            OP_SCAN:          rd_en = (rd_idx_reg < count_reg) && !hit_reg;
            OP_SHIFT:         rd_en = rd_idx_reg > hit_idx_ext;
            OP_COMP, OP_STAT: rd_en = rd_idx_reg < count_reg;
            default:          rd_en = 1'b0;
        endcase
    end

    // Next-state logic of the datapath registers and the write port
    always_comb begin
        base_next      = base_reg;
        hbytes_next    = hbytes_reg;
        init_pend_next = init_pend_reg;
        cmd_next       = cmd_reg;
        sz_next        = sz_reg;
        fa_next        = fa_reg;
        bad_next       = bad_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        a_next         = a_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_size_next  = hit_size_reg;
        res_addr_next  = res_addr_reg;
        status_next    = status_reg;
        w_next         = w_reg;
        pend_next      = pend_reg;
        pend_vld_next  = pend_vld_reg;
        used_next      = used_reg;
        frb_next       = frb_reg;
        fb_next        = fb_reg;
        out_addr_next  = out_addr_reg;
        out_st_next    = out_st_reg;
        out_used_next  = out_used_reg;
        out_free_next  = out_free_reg;
        out_tot_next   = out_tot_reg;
        out_fb_next    = out_fb_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        case (op)
            OP_LOAD: begin
                cmd_next      = s_command;
                sz_next       = aligned[SIZE_W-1:0];
                fa_next       = s_free_address;
                bad_next      = (s_command == CMD_ALLOC) &&
                                ((s_request_size == '0) ||
                                 (s_request_size > 32'hFFFF_FFF8) ||
                                 (aligned[ADDR_W-1:SIZE_W] != '0));
                status_next   = bad_next ? ST_BAD_SIZE : ST_OK;
                res_addr_next = '0;
                rd_idx_next   = '0;
                a_next        = base_reg;
                hit_next      = 1'b0;
            end
            OP_MISS: begin
                status_next = (cmd_reg == CMD_FREE) ? ST_BAD_FREE : ST_NO_MEM;
            end
            OP_SCAN: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (p_vld_reg && !hit_reg) begin
                    if (cmd_reg == CMD_FREE) begin
                        hit_next = (a_reg + HDR_A) == fa_reg;
                    end else begin
                        hit_next = rdata_reg.free && (rdata_reg.size >= sz_reg);
                        if (hit_next) begin
                            res_addr_next = a_reg + HDR_A;
                        end
                    end
                    hit_idx_next  = p_idx_reg;
                    hit_size_next = rdata_reg.size;
                    a_next        = a_reg + HDR_A + ADDR_W'(rdata_reg.size);
                end
            end
            OP_SHIFT_START: begin
                rd_idx_next = count_reg - CNT_W'(1);
            end
            OP_SHIFT: begin
                // Move entries one place up, last one first
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg - CNT_W'(1);
                end
                if (p_vld_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = p_idx_reg + IDX_W'(1);
                    wr_data = rdata_reg;
                end
            end
            OP_WR_ALLOC: begin
                wr_en   = 1'b1;
                wr_addr = hit_idx_reg;
                wr_data = '{free: 1'b0, size: sz_reg};
            end
            OP_WR_REM: begin
                wr_en      = 1'b1;
                wr_addr    = hit_idx_reg + IDX_W'(1);
                wr_data    = '{free: 1'b1, size: rem - HDR_S};
                count_next = count_reg + CNT_W'(1);
            end
            OP_WR_MARK: begin
                wr_en   = 1'b1;
                wr_addr = hit_idx_reg;
                wr_data = '{free: 1'b0, size: hit_size_reg};
            end
            OP_COMP_START: begin
                rd_idx_next   = '0;
                w_next        = '0;
                pend_vld_next = 1'b0;
            end
            OP_COMP: begin
                // Stream the table and fold neighboring free blocks together
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (p_vld_reg) begin
                    if (!pend_vld_reg) begin
                        pend_next     = ef;
                        pend_vld_next = 1'b1;
                    end else if (pend_reg.free && ef.free) begin
                        pend_next.size = pend_reg.size + HDR_S + ef.size;
                    end else begin
                        wr_en     = 1'b1;
                        wr_addr   = w_reg;
                        wr_data   = pend_reg;
                        w_next    = w_reg + IDX_W'(1);
                        pend_next = ef;
                    end
                end
            end
            OP_COMP_END: begin
                wr_en      = 1'b1;
                wr_addr    = w_reg;
                wr_data    = pend_reg;
                count_next = CNT_W'(w_reg) + CNT_W'(1);
            end
            OP_STAT_START: begin
                rd_idx_next = '0;
                used_next   = '0;
                frb_next    = '0;
                fb_next     = '0;
            end
            OP_STAT: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (p_vld_reg) begin
                    if (rdata_reg.free) begin
                        frb_next = frb_reg + rdata_reg.size;
                        fb_next  = fb_reg + CNT_W'(1);
                    end else begin
                        used_next = used_reg + rdata_reg.size;
                    end
                end
            end
            OP_OUT: begin
                out_addr_next = res_addr_reg;
                out_st_next   = status_reg;
                out_used_next = used_reg;
                out_free_next = frb_reg;
                out_tot_next  = STAT_W'(count_reg);
                out_fb_next   = STAT_W'(fb_reg);
            end
            default: begin
            end
        endcase

        // Rebuild the table as one free block after reset or a register write
        if (init_pend_reg) begin
            wr_en          = 1'b1;
            wr_addr        = '0;
            wr_data.free   = 1'b1;
            wr_data.size   = (hbytes_reg >= HDR_S) ? (hbytes_reg - HDR_S) : '0;
            count_next     = CNT_W'(1);
            init_pend_next = 1'b0;
        end

        // Configuration writes
        if (cfg_we) begin
            if (cfg_index == REG_HEAP_BASE) begin
                base_next      = cfg_data;
                init_pend_next = 1'b1;
            end else if (cfg_index == REG_HEAP_BYTES) begin
                hbytes_next    = cfg_data[SIZE_W-1:0];
                init_pend_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= HEAP_BASE_RST;
            hbytes_reg    <= HEAP_BYTES_RST;
            init_pend_reg <= 1'b1;
            count_reg     <= CNT_W'(1);
            p_vld_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end else begin
            base_reg      <= base_next;
            hbytes_reg    <= hbytes_next;
            init_pend_reg <= init_pend_next;
            count_reg     <= count_next;
            p_vld_reg     <= rd_en;
            hit_reg       <= hit_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        sz_reg       <= sz_next;
        fa_reg       <= fa_next;
        bad_reg      <= bad_next;
        rd_idx_reg   <= rd_idx_next;
        p_idx_reg    <= rd_addr;
        a_reg        <= a_next;
        hit_idx_reg  <= hit_idx_next;
        hit_size_reg <= hit_size_next;
        res_addr_reg <= res_addr_next;
        status_reg   <= status_next;
        w_reg        <= w_next;
        pend_reg     <= pend_next;
        used_reg     <= used_next;
        frb_reg      <= frb_next;
        fb_reg       <= fb_next;
        out_addr_reg <= out_addr_next;
        out_st_reg   <= out_st_next;
        out_used_reg <= out_used_next;
        out_free_reg <= out_free_next;
        out_tot_reg  <= out_tot_next;
        out_fb_reg   <= out_fb_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign m_result_address = out_addr_reg;
    assign m_status         = out_st_reg;
    assign m_used_bytes     = out_used_reg;
    assign m_free_bytes     = out_free_reg;
    assign m_total_blocks   = out_tot_reg;
    assign m_free_count     = out_fb_reg;

endmodule

// ===== rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: steps the datapath through its passes and runs the
// input and result handshakes.
// ----------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_op_t  op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SHIFT0,
        S_SHIFT,
        S_SPLIT0,
        S_SPLIT1,
        S_MARK,
        S_COMP0,
        S_COMP,
        S_STAT0,
        S_STAT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE) && !sts.init_pend;
    assign m_valid = m_valid_reg;

    // Next state and operation
    always_comb begin
        state_next   = state_reg;
        op           = OP_NONE;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    op         = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = sts.bad ? S_STAT0 : S_SCAN;
            end
            S_SCAN: begin
                if (sts.hit) begin
                    if (sts.is_free) begin
                        state_next = S_COMP0;
                    end else if (sts.split) begin
                        state_next = S_SHIFT0;
                    end else begin
                        state_next = S_MARK;
                    end
                end else if (sts.scan_done) begin
                    op         = OP_MISS;
                    state_next = S_STAT0;
                end else begin
                    op = OP_SCAN;
                end
            end
            S_SHIFT0: begin
                op         = OP_SHIFT_START;
                state_next = S_SHIFT;
            end
            S_SHIFT: begin
                if (sts.shift_done) begin
                    state_next = S_SPLIT0;
                end else begin
                    op = OP_SHIFT;
                end
            end
            S_SPLIT0: begin
                op         = OP_WR_ALLOC;
                state_next = S_SPLIT1;
            end
            S_SPLIT1: begin
                op         = OP_WR_REM;
                state_next = S_STAT0;
            end
            S_MARK: begin
                op         = OP_WR_MARK;
                state_next = S_STAT0;
            end
            S_COMP0: begin
                op         = OP_COMP_START;
                state_next = S_COMP;
            end
            S_COMP: begin
                if (sts.comp_done) begin
                    op         = OP_COMP_END;
                    state_next = S_STAT0;
                end else begin
                    op = OP_COMP;
                end
            end
            S_STAT0: begin
                op         = OP_STAT_START;
                state_next = S_STAT;
            end
            S_STAT: begin
                if (sts.stat_done) begin
                    state_next = S_OUT;
                end else begin
                    op = OP_STAT;
                end
            end
            S_OUT: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    op           = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== dv/first_fit_heap_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit_tb
// Self-checking bench for the first-fit heap allocator.
// ----------------------------------------------------------------------------
// Requests go in on the s_ channel while a behavioral copy of the block table
// works out each reply: first-fit placement, splits, merges on free and the
// usage counts. Replies on the m_ channel are checked field by field in order.
// A short table of directed requests runs from reset, then several heap
// layouts (low, high and wrapping bases, tiny to maximum sizes) each get a
// burst of random alloc/free traffic, with random stalls on both sides in the first four.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit_tb
    import ffha_pkg::*;
();

    localparam int NBLK     = 64;
    localparam int HDR      = 12;
    localparam int DRAIN_CY = 250;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        status;
        logic [SIZE_W-1:0] used;
        logic [SIZE_W-1:0] freeb;
        logic [STAT_W-1:0] total;
        logic [STAT_W-1:0] nfree;
    } reply_t;

    typedef struct {
        logic        cmd;
        logic [31:0] rsz;
        logic [31:0] fad;
        bit          typed;
        reply_t      reply;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_command = CMD_ALLOC;
    logic [ADDR_W-1:0]    s_request_size = '0;
    logic [ADDR_W-1:0]    s_free_address = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [ADDR_W-1:0]    m_result_address;
    logic [1:0]           m_status;
    logic [SIZE_W-1:0]    m_used_bytes;
    logic [SIZE_W-1:0]    m_free_bytes;
    logic [STAT_W-1:0]    m_total_blocks;
    logic [STAT_W-1:0]    m_free_count;

    // Heap table copy
    logic [31:0]     heap_base_m;
    logic [23:0]     heap_bytes_m;
    logic [23:0]     blk_size [NBLK];
    bit              blk_free [NBLK];
    int unsigned     blk_cnt;

    reply_t          pending_replies[$];
    int              errors = 0;
    int              words_in = 0;
    int              words_out = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_left = 0;
    row_t            dir_rows[$];

    first_fit_heap_allocator_unit dut (.*);

    always #1 aclk = ~aclk;

    // ---------------- predictor ----------------
    function automatic void table_rebuild();
        for (int i = 0; i < NBLK; i++) begin
            blk_size[i] = '0;
            blk_free[i] = 1'b0;
        end
        blk_size[0] = (heap_bytes_m >= HDR) ? heap_bytes_m - HDR : '0;
        blk_free[0] = 1'b1;
        blk_cnt = 1;
    endfunction

    function automatic logic [31:0] block_payload(int unsigned idx);
        logic [31:0] a;
        a = heap_base_m;
        for (int unsigned k = 0; k < idx; k++)
            a = a + HDR + blk_size[k];
        return a + HDR;
    endfunction

    function automatic void coalesce();
        int unsigned i;
        i = 0;
        while (i + 1 < blk_cnt) begin
            if (blk_free[i] && blk_free[i+1]) begin
                blk_size[i] = blk_size[i] + HDR + blk_size[i+1];
                for (int unsigned k = i + 1; k + 1 < blk_cnt; k++) begin
                    blk_size[k] = blk_size[k+1];
                    blk_free[k] = blk_free[k+1];
                end
                blk_cnt--;
                blk_size[blk_cnt] = '0;
                blk_free[blk_cnt] = 1'b0;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic reply_t heap_model_step(logic cmd, logic [31:0] rsz,
                                               logic [31:0] fad);
        reply_t      r;
        logic [31:0] sz;
        logic [31:0] rem;
        logic [31:0] a;
        logic [31:0] used;
        logic [31:0] fr;
        int unsigned nf;
        bit          done;
        r = '0;
        done = 0;
        if (cmd == CMD_ALLOC) begin
            sz = (rsz + 32'd7) & ~32'd7;
            if (rsz == 0 || rsz > 32'hFFFF_FFF8 || sz > 32'h00FF_FFFF) begin
                r.status = ST_BAD_SIZE;
            end else begin
                r.status = ST_NO_MEM;
                for (int unsigned i = 0; i < blk_cnt && !done; i++) begin
                    if (blk_free[i] && blk_size[i] >= sz) begin
                        rem = blk_size[i] - sz;
                        // split if the remainder is large enough and the table is not already full
                        if (rem > HDR + 8 && blk_cnt < NBLK) begin
                            for (int unsigned k = blk_cnt; k > i + 1; k--) begin
                                blk_size[k] = blk_size[k-1];
                                blk_free[k] = blk_free[k-1];
                            end
                            blk_size[i+1] = rem - HDR;
                            blk_free[i+1] = 1'b1;
                            blk_size[i] = sz;
                            blk_cnt++;
                        end
                        blk_free[i] = 1'b0;
                        r.addr = block_payload(i);
                        r.status = ST_OK;
                        done = 1;
                    end
                end
            end
        end else begin
            r.status = ST_BAD_FREE;
            a = heap_base_m;
            for (int unsigned i = 0; i < blk_cnt && !done; i++) begin
                if (a + HDR == fad) begin
                    blk_free[i] = 1'b1;
                    coalesce();
                    r.status = ST_OK;
                    done = 1;
                end
                a = a + HDR + blk_size[i];
            end
        end
        used = 0;
        fr = 0;
        nf = 0;
        for (int unsigned i = 0; i < blk_cnt; i++) begin
            if (blk_free[i]) begin
                fr += blk_size[i];
                nf++;
            end else begin
                used += blk_size[i];
            end
        end
        r.used = used[23:0];
        r.freeb = fr[23:0];
        r.total = blk_cnt[6:0];
        r.nfree = nf[6:0];
        return r;
    endfunction

    // ---------------- driving ----------------
    // Offer one request word; called and returns at a falling edge.
    task automatic offer(input logic cmd, input logic [31:0] rsz,
                         input logic [31:0] fad, input bit typed = 0,
                         input reply_t typed_reply = '0);
        reply_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_command = cmd;
        s_request_size = rsz;
        s_free_address = fad;
        do @(posedge aclk); while (!s_ready);
        r = heap_model_step(cmd, rsz, fad);
        pending_replies.push_back(typed ? typed_reply : r);
        words_in++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending_replies.size() != 0)
            @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        drain();
        repeat (4) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_HEAP_BASE)
            heap_base_m = val;
        else
            heap_bytes_m = val[23:0];
        table_rebuild();
    endtask

    function automatic logic [31:0] pick_free_target();
        if ($urandom_range(0, 99) < 85)
            return block_payload($urandom_range(0, blk_cnt - 1));
        return heap_base_m + $urandom_range(0, 64);
    endfunction

    function automatic logic [31:0] pick_alloc_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(1, 256);
        if (p < 90) return $urandom_range(1, heap_bytes_m > 1 ? heap_bytes_m : 1);
        return $urandom_range(1, 8);
    endfunction

    // Receiver: random stalls plus the long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (pending_replies.size() == 0) begin
                $display("ERROR %0t: reply word with nothing pending", $realtime);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (m_result_address !== want.addr)
                    report_mismatch("result_address", m_result_address, want.addr);
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_used_bytes !== want.used)
                    report_mismatch("used_bytes", m_used_bytes, want.used);
                if (m_free_bytes !== want.freeb)
                    report_mismatch("free_bytes", m_free_bytes, want.freeb);
                if (m_total_blocks !== want.total)
                    report_mismatch("total_blocks", m_total_blocks, want.total);
                if (m_free_count !== want.nfree)
                    report_mismatch("free_count", m_free_count, want.nfree);
            end
        end
    end

    // Watchdog
    initial begin
        #4000000;
        $display("first_fit_heap_allocator_unit: mismatch");
        $finish;
    end

    function automatic row_t mk_row(logic cmd, logic [31:0] rsz, logic [31:0] fad,
                                    bit typed = 0, reply_t rep = '0);
        row_t r;
        r.cmd = cmd;
        r.rsz = rsz;
        r.fad = fad;
        r.typed = typed;
        r.reply = rep;
        return r;
    endfunction

    // ---------------- stimulus ----------------
    initial begin
        logic [31:0] base_set [6];
        logic [23:0] size_set [6];
        reply_t      bad_sz;
        int          p;
        base_set = '{32'h0010_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'hFFFF_FFF0, 32'h0000_0000, 32'h8000_0000};
        size_set = '{24'h01_0000, 24'd32, 24'hFF_FFFF, 24'd4096, 24'd2048, 24'd8};
        base_set[4] = $urandom;

        heap_base_m = HEAP_BASE_RST;
        heap_bytes_m = HEAP_BYTES_RST;
        table_rebuild();

        // Hold reset, then release
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed table from the reset layout
        bad_sz = '{addr: 0, status: ST_BAD_SIZE, used: 0, freeb: 24'd65524,
                   total: 1, nfree: 1};
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF, 1, bad_sz));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 1, bad_sz));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'hFFFF_FFF9, 32'd0, 1, bad_sz));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'h0100_0000, 32'd0, 1, bad_sz));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'h00FF_FFF9, 32'd0, 1, bad_sz));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'h00FF_FFF8, 32'd0, 1,
            '{addr: 0, status: ST_NO_MEM, used: 0, freeb: 24'd65524, total: 1, nfree: 1}));
        dir_rows.push_back(mk_row(CMD_FREE, 32'hFFFF_FFFF, 32'd0, 1,
            '{addr: 0, status: ST_BAD_FREE, used: 0, freeb: 24'd65524, total: 1, nfree: 1}));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'd1, 32'd0, 1,
            '{addr: 32'h0010_000C, status: ST_OK, used: 8, freeb: 24'd65504,
              total: 2, nfree: 1}));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'd16, 32'd0));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'd24, 32'd0));
        dir_rows.push_back(mk_row(CMD_FREE, 32'd0, 32'h0010_000C));
        dir_rows.push_back(mk_row(CMD_FREE, 32'd0, 32'h0010_000C));
        dir_rows.push_back(mk_row(CMD_FREE, 32'd0, 32'h0010_0010));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'd8, 32'd0));
        dir_rows.push_back(mk_row(CMD_FREE, 32'd0, 32'h0010_0020));
        dir_rows.push_back(mk_row(CMD_FREE, 32'd0, 32'h0010_000C));
        dir_rows.push_back(mk_row(CMD_ALLOC, 32'd65524, 32'd0));
        dir_rows.push_back(mk_row(CMD_FREE, 32'd0, 32'h0010_000C));

        send_idle_pct = 11;
        recv_idle_pct = 66;
        foreach (dir_rows[i])
            offer(dir_rows[i].cmd, dir_rows[i].rsz, dir_rows[i].fad,
                  dir_rows[i].typed, dir_rows[i].reply);

        // Random phases over several heap layouts
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 66;
                recv_idle_pct = 11;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_HEAP_BASE, base_set[ph]);
            write_reg(REG_HEAP_BYTES, {8'h00, size_set[ph]});

            // Offer more small allocations than the table has entries
            if (ph == 0 || ph == 5) begin
                for (int n = 0; n < 70; n++)
                    offer(CMD_ALLOC, $urandom_range(1, 16), $urandom);
            end
            // Stall the receiver long while requests keep coming
            if (ph == 3)
                hold_left = 400;

            for (int n = 0; n < 105; n++) begin
                if (n == 50)
                    drain();
                p = $urandom_range(0, 99);
                if (p < 6)
                    offer(1'($urandom_range(0, 1)), $urandom, $urandom);
                else if (p < 55)
                    offer(CMD_ALLOC, pick_alloc_size(), $urandom);
                else
                    offer(CMD_FREE, $urandom, pick_free_target());
            end
        end

        // Wait for the last replies, then let the block settle
        s_valid = 1'b0;
        while (pending_replies.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CY) @(posedge aclk);

        $display("Ran %0d requests, %0d replies checked over 6 heap layouts", words_in,
                 words_out);
        $display("Covered bad sizes, bad frees, full table, splits and merges");
        if (errors == 0 && pending_replies.size() == 0)
            $display("first_fit_heap_allocator_unit: match");
        else
            $display("first_fit_heap_allocator_unit: mismatch");
        $finish;
    end

endmodule
